/* hw/rtl/scpa_pkg.sv */
// shared types and constants for the size class pool allocator
package scpa_pkg;

  localparam int unsigned NumClasses = 10;
  localparam int unsigned CellsPerPool = 128;
  localparam int unsigned PoolsPerClass = 4;

  localparam int unsigned ModeW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ClassW = 4;
  localparam int unsigned PoolW = 2;
  localparam int unsigned CellW = 7;
  localparam int unsigned OffsetW = 18;
  localparam int unsigned SizeW = 16;
  localparam int unsigned AlignW = 7;

  localparam logic [ModeW-1:0] ModeAlloc = 2'd0;
  localparam logic [ModeW-1:0] ModeFree = 2'd1;
  localparam logic [ModeW-1:0] ModeClean = 2'd2;

  localparam logic [StatusW-1:0] StOk = 3'd0;
  localparam logic [StatusW-1:0] StNotSet = 3'd1;
  localparam logic [StatusW-1:0] StTooLarge = 3'd2;
  localparam logic [StatusW-1:0] StNoPool = 3'd3;
  localparam logic [StatusW-1:0] StBadAddr = 3'd4;
  localparam logic [StatusW-1:0] StAlreadyFree = 3'd5;

  typedef struct packed {
    logic                ok;
    logic [StatusW-1:0]  status;
    logic [ClassW-1:0]   cls;
    logic [PoolW-1:0]    pool;
    logic [CellW-1:0]    cell_id;
    logic [OffsetW-1:0]  offset;
  } result_t;

  function automatic logic align_legal(input logic [AlignW-1:0] a);
    return (a == 7'd2) || (a == 7'd4) || (a == 7'd8) || (a == 7'd16) ||
           (a == 7'd32) || (a == 7'd64);
  endfunction

endpackage

/* hw/rtl/size_class_pool_allocator.sv */
// top level of the size class pool allocator: control, pool table and cell memories
// allocate: a hit ends the scan at the first live pool of the class with a free cell;
//   a pool bring-up takes a full scan, a second scan for a pool that is not live and a fill
// free is set by the 18-step serial divider; cleanup reads and checks each pool in turn
// one item at a time; the next transfer is taken the cycle after the result transfer
// reset clears the pool table and the control state; cell memories need no clearing
module size_class_pool_allocator import scpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[1:0], size_bytes[17:2], size_class[21:18], pool_index[23:22], cell_offset[41:24]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ok[0], status[3:1], out_class[7:4], out_pool[9:8], out_cell[16:10], out_offset[34:17]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned NPools = NumClasses * PoolsPerClass;
  localparam int unsigned PIdxW = (NPools > 1) ? $clog2(NPools) : 1;
  localparam int unsigned PcCntW = $clog2(PoolsPerClass + 1);
  localparam int unsigned CIdxW = $clog2(CellsPerPool);
  localparam int unsigned FcW = $clog2(CellsPerPool + 1);
  localparam int unsigned NCells = NPools * CellsPerPool;
  localparam int unsigned MAdrW = $clog2(NCells);
  localparam int unsigned PCntW = $clog2(NPools + 1);
  localparam int unsigned CellSzW = 11;
  localparam int unsigned PoolBytesW = CellSzW + CIdxW + 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_ARD    = 11'b00000000100,
    S_ACHK   = 11'b00000001000,
    S_FILL   = 11'b00000010000,
    S_POP    = 11'b00000100000,
    S_POPW   = 11'b00001000000,
    S_FDIV   = 11'b00010000000,
    S_FCHK   = 11'b00100000000,
    S_CLN    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [AlignW-1:0] align_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == 2'd0);
  assign prdata = {25'd0, align_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= '0;
    end else if (cfg_wr) begin
      align_q <= pwdata[AlignW-1:0];
    end
  end

  // pool table: live bit and free count per pool, reset in flip-flops
  logic [NPools-1:0] live_q;
  logic [FcW-1:0]    fcnt_q [NPools];
  logic              pt_we;
  logic [PIdxW-1:0]  pt_wa;
  logic              pt_wlive;
  logic [FcW-1:0]    pt_wfc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      for (int i = 0; i < NPools; i++) fcnt_q[i] <= '0;
    end else if (pt_we) begin
      live_q[pt_wa] <= pt_wlive;
      fcnt_q[pt_wa] <= pt_wfc;
    end
  end

  // cell memories
  logic [CIdxW-1:0] stack_mem [NCells];
  logic             taken_mem [NCells];
  logic             st_we, tk_we, tk_wd;
  logic [MAdrW-1:0] st_wa, st_ra, tk_wa, tk_ra;
  logic [CIdxW-1:0] st_wd, st_rd_q;
  logic             tk_rd_q;

  always_ff @(posedge clk_i) begin
    if (st_we) stack_mem[st_wa] <= st_wd;
    st_rd_q <= stack_mem[st_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tk_we) taken_mem[tk_wa] <= tk_wd;
    tk_rd_q <= taken_mem[tk_ra];
  end

  // item registers
  logic [ModeW-1:0]   mode_q, mode_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic [ClassW-1:0]  cls_q, cls_d;
  logic [PoolW-1:0]   pidx_q, pidx_d;
  logic [OffsetW-1:0] off_q, off_d;
  logic [PcCntW-1:0]  scan_q, scan_d;
  logic               fill_q, fill_d;
  logic [CIdxW:0]     fcell_q, fcell_d;
  logic [PIdxW-1:0]   k_q, k_d;
  logic [FcW-1:0]     fc_q, fc_d;
  logic               lv_q, lv_d;
  logic [PCntW-1:0]   ck_q, ck_d;
  logic [CIdxW-1:0]   cell_q, cell_d;
  result_t            res_q, res_d;

  logic               div_start, div_done;
  logic [OffsetW-1:0] div_quot, div_rem;
  logic [CellSzW-1:0] csize;
  logic [PoolBytesW-1:0] pool_bytes;
  logic [ClassW-1:0]  want_cls;
  logic [PIdxW-1:0]   k_scan;
  logic [PIdxW+CIdxW-1:0] base;
  logic [OffsetW-1:0] prod;

  scpa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_q),
    .divisor_i  (OffsetW'(csize)),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign csize = CellSzW'((CellSzW)'(2) << cls_q) + CellSzW'(align_q);
  assign pool_bytes = PoolBytesW'(csize) * PoolBytesW'(CellsPerPool);
  assign k_scan = PIdxW'(cls_q * PoolsPerClass + 32'(scan_q));
  assign base = (PIdxW+CIdxW)'(k_q) << CIdxW;
  assign prod = OffsetW'(cell_q) * OffsetW'(csize);

  always_comb begin
    want_cls = ClassW'(NumClasses - 1);
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (32'(size_q) <= (32'd2 << c)) want_cls = ClassW'(c);
    end
  end

  function automatic result_t fail(input logic [StatusW-1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    size_d = size_q;
    cls_d = cls_q;
    pidx_d = pidx_q;
    off_d = off_q;
    scan_d = scan_q;
    fill_d = fill_q;
    fcell_d = fcell_q;
    k_d = k_q;
    fc_d = fc_q;
    lv_d = lv_q;
    ck_d = ck_q;
    cell_d = cell_q;
    res_d = res_q;
    pt_we = 1'b0;
    pt_wa = k_q;
    pt_wlive = 1'b1;
    pt_wfc = fc_q;
    st_we = 1'b0;
    st_wa = MAdrW'(base + (PIdxW+CIdxW)'(fcell_q[CIdxW-1:0]));
    st_wd = fcell_q[CIdxW-1:0];
    st_ra = MAdrW'(base + (PIdxW+CIdxW)'(fc_q[CIdxW-1:0]));
    tk_we = 1'b0;
    tk_wa = st_wa;
    tk_wd = 1'b0;
    tk_ra = MAdrW'(base + (PIdxW+CIdxW)'(div_quot[CIdxW-1:0]));
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d = s_axis_tdata[1:0];
          size_d = s_axis_tdata[17:2];
          cls_d = s_axis_tdata[21:18];
          pidx_d = s_axis_tdata[23:22];
          off_d = s_axis_tdata[41:24];
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        scan_d = '0;
        fill_d = 1'b0;
        ck_d = '0;
        if (!align_legal(align_q)) begin
          res_d = fail(StNotSet);
          state_d = S_OUT;
        end else if (mode_q == ModeAlloc) begin
          if (32'(size_q) > (32'd2 << (NumClasses - 1))) begin
            res_d = fail(StTooLarge);
            state_d = S_OUT;
          end else begin
            cls_d = want_cls;
            state_d = S_ARD;
          end
        end else if (mode_q == ModeFree) begin
          if (32'(cls_q) >= NumClasses || 32'(pidx_q) >= PoolsPerClass) begin
            res_d = fail(StBadAddr);
            state_d = S_OUT;
          end else begin
            k_d = PIdxW'(cls_q * PoolsPerClass + 32'(pidx_q));
            div_start = 1'b1;
            state_d = S_FDIV;
          end
        end else if (mode_q == ModeClean) begin
          state_d = S_CLN;
        end else begin
          res_d = fail(StBadAddr);
          state_d = S_OUT;
        end
      end
      S_ARD: begin
        // read one pool entry of the scan
        k_d = k_scan;
        lv_d = live_q[k_scan];
        fc_d = fcnt_q[k_scan];
        state_d = S_ACHK;
      end
      S_ACHK: begin
        if (!fill_q && lv_q && fc_q != '0) begin
          pidx_d = PoolW'(scan_q);
          state_d = S_POP;
        end else if (fill_q && !lv_q) begin
          pidx_d = PoolW'(scan_q);
          fcell_d = '0;
          state_d = S_FILL;
        end else if (32'(scan_q) == PoolsPerClass - 1) begin
          if (fill_q) begin
            res_d = fail(StNoPool);
            state_d = S_OUT;
          end else begin
            fill_d = 1'b1;
            scan_d = '0;
            state_d = S_ARD;
          end
        end else begin
          scan_d = scan_q + 1'b1;
          state_d = S_ARD;
        end
      end
      S_FILL: begin
        st_we = 1'b1;
        tk_we = 1'b1;
        fcell_d = fcell_q + 1'b1;
        if (32'(fcell_q) == CellsPerPool - 1) begin
          fc_d = FcW'(CellsPerPool);
          state_d = S_POP;
        end
      end
      S_POP: begin
        fc_d = fc_q - 1'b1;
        st_ra = MAdrW'(base + (PIdxW+CIdxW)'(fc_d[CIdxW-1:0]));
        pt_we = 1'b1;
        pt_wlive = 1'b1;
        pt_wfc = fc_d;
        state_d = S_POPW;
      end
      S_POPW: begin
        cell_d = st_rd_q;
        tk_we = 1'b1;
        tk_wa = MAdrW'(base + (PIdxW+CIdxW)'(st_rd_q));
        tk_wd = 1'b1;
        state_d = S_OUT;
        res_d = '0;
        res_d.ok = 1'b1;
        res_d.cls = cls_q;
        res_d.pool = pidx_q;
        res_d.cell_id = CellW'(st_rd_q);
        res_d.offset = '0;
        mode_d = ModeAlloc;
        state_d = S_CLN;
        ck_d = PCntW'(NPools);
      end
      S_FDIV: begin
        lv_d = live_q[k_q];
        fc_d = fcnt_q[k_q];
        if (div_done) begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!lv_q || 32'(off_q) >= 32'(pool_bytes) || div_rem != '0) begin
          res_d = fail(StBadAddr);
          state_d = S_OUT;
        end else if (!tk_rd_q || 32'(fc_q) >= CellsPerPool) begin
          res_d = fail(StAlreadyFree);
          state_d = S_OUT;
        end else begin
          st_we = 1'b1;
          st_wa = MAdrW'(base + (PIdxW+CIdxW)'(fc_q[CIdxW-1:0]));
          st_wd = div_quot[CIdxW-1:0];
          tk_we = 1'b1;
          tk_wa = MAdrW'(base + (PIdxW+CIdxW)'(div_quot[CIdxW-1:0]));
          tk_wd = 1'b0;
          pt_we = 1'b1;
          pt_wlive = 1'b1;
          pt_wfc = fc_q + 1'b1;
          res_d = '0;
          res_d.ok = 1'b1;
          state_d = S_OUT;
        end
      end
      S_CLN: begin
        if (mode_q == ModeAlloc) begin
          // offset multiply, registered before output
          res_d.offset = prod;
          state_d = S_OUT;
        end else if (32'(ck_q) == NPools) begin
          res_d = '0;
          res_d.ok = 1'b1;
          state_d = S_OUT;
        end else if (!fill_q) begin
          // read one pool entry, check it next cycle
          lv_d = live_q[PIdxW'(ck_q)];
          fc_d = fcnt_q[PIdxW'(ck_q)];
          fill_d = 1'b1;
        end else begin
          if (lv_q && 32'(fc_q) == CellsPerPool) begin
            pt_we = 1'b1;
            pt_wa = PIdxW'(ck_q);
            pt_wlive = 1'b0;
            pt_wfc = '0;
          end
          ck_d = ck_q + 1'b1;
          fill_d = 1'b0;
        end
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    size_q <= size_d;
    cls_q <= cls_d;
    pidx_q <= pidx_d;
    off_q <= off_d;
    scan_q <= scan_d;
    fill_q <= fill_d;
    fcell_q <= fcell_d;
    k_q <= k_d;
    fc_q <= fc_d;
    lv_q <= lv_d;
    ck_q <= ck_d;
    cell_q <= cell_d;
    res_q <= res_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {5'd0, res_q.offset, res_q.cell_id, res_q.pool, res_q.cls,
                         res_q.status, res_q.ok};

endmodule

/* hw/rtl/scpa_divider.sv */
// restoring divider, one quotient bit per cycle
module scpa_divider import scpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [OffsetW-1:0] dividend_i,
  input  logic [OffsetW-1:0] divisor_i,
  output logic               done_o,
  output logic [OffsetW-1:0] quot_o,
  output logic [OffsetW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(OffsetW + 1);

  logic [OffsetW-1:0] quot_q, quot_d;
  logic [OffsetW-1:0] rem_q, rem_d;
  logic [OffsetW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [OffsetW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quot_q[OffsetW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CntW'(OffsetW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = OffsetW'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[OffsetW-2:0], 1'b1};
      end else begin
        rem_d = trial[OffsetW-1:0];
        quot_d = {quot_q[OffsetW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o = rem_q;

endmodule
